### rtl/scd_pkg.sv
// ----------------------------------------------------------------------------
// scd_pkg
// Shared types, constants and elaboration-time tables for the stain color
// deconvolution core: optical density and threshold tables, base-2 log helper.
// ----------------------------------------------------------------------------
package scd_pkg;

	localparam int PIX_W   = 8;
	localparam int COEF_W  = 16;
	localparam int OD_W    = 17;
	localparam int PROD_W  = COEF_W + OD_W;
	localparam int SUM_W   = PROD_W + 2;
	localparam int LEVEL_W = 8;
	localparam int LOG_FRAC = 24;

	// Coefficient reset values (hematoxylin row)
	localparam logic signed [COEF_W-1:0] COEF_RED_RST   = 16'sd7730;
	localparam logic signed [COEF_W-1:0] COEF_GREEN_RST = 16'sd1139;
	localparam logic signed [COEF_W-1:0] COEF_BLUE_RST  = -16'sd6371;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_COEF_RED   = 2'd0,
		REG_COEF_GREEN = 2'd1,
		REG_COEF_BLUE  = 2'd2
	} cfg_reg_t;

	typedef logic [255:0][OD_W-1:0] od_tab_t;
	typedef logic [255:0][63:0]     thr_tab_t;

	// log2(x) for 1 <= x <= 511, LOG_FRAC fraction bits, truncating squaring
	function automatic logic [63:0] fx_log2(input logic [8:0] x);
		logic [63:0] n;
		logic [63:0] y;
		logic [63:0] frac;
		n    = '0;
		frac = '0;
		for (int i = 1; i < 9; i++) begin
			if ((x >> i) != 9'd0) n = 64'(i);
		end
		y = 64'(x) << (64'(LOG_FRAC) - n);
		for (int i = 0; i < LOG_FRAC; i++) begin
			y    = (y * y) >> LOG_FRAC;
			frac = frac << 1;
			if (y >= (64'd2 << LOG_FRAC)) begin
				y    = y >> 1;
				frac = frac | 64'd1;
			end
		end
		return (n << LOG_FRAC) | frac;
	endfunction

	localparam longint LOG2_255 = longint'(fx_log2(9'd255));

	// Optical density per channel value, signed Q9.8, rounded to nearest
	function automatic od_tab_t build_od_table();
		od_tab_t tab;
		longint  num;
		longint  q;
		for (int c = 0; c < 256; c++) begin
			num = 64'sd65280 * (LOG2_255 - longint'(fx_log2(9'(c + 1))));
			if (num >= 0)
				q = (num + LOG2_255 / 2) / LOG2_255;
			else
				q = -((-num + LOG2_255 / 2) / LOG2_255);
			tab[c] = OD_W'(q);
		end
		return tab;
	endfunction

	// Upper bound on the weighted sum for each output level k:
	// level >= k holds exactly when sum <= floor((L255 - thr_k) * den / L255)
	function automatic thr_tab_t build_thr_table(input int frac_bits);
		thr_tab_t tab;
		longint   a;
		longint   d;
		tab[0] = '0;
		d = 64'sd255 <<< (frac_bits + 8);
		for (int k = 1; k < 256; k++) begin
			a = LOG2_255 - (longint'(fx_log2(9'(2 * k - 1))) - (64'sd1 <<< LOG_FRAC));
			tab[k] = 64'((a * d) / LOG2_255);
		end
		return tab;
	endfunction

	localparam od_tab_t OD_TABLE = build_od_table();

endpackage

### rtl/scd_od_weight.sv
// ----------------------------------------------------------------------------
// scd_od_weight
// Front of the pipeline: density lookup, coefficient multiply, sum and clamp.
// ----------------------------------------------------------------------------
module scd_od_weight import scd_pkg::*; #(
	parameter int COEF_FRAC_BITS = 12
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_vld,
	input  logic [PIX_W-1:0]                 red,
	input  logic [PIX_W-1:0]                 green,
	input  logic [PIX_W-1:0]                 blue,
	input  logic signed [COEF_W-1:0]         coef_red,
	input  logic signed [COEF_W-1:0]         coef_green,
	input  logic signed [COEF_W-1:0]         coef_blue,
	output logic                             vld_s3,
	output logic [COEF_FRAC_BITS+17:0]       sum_s3
);

	// sums at or above 512 (in density units) all map to level zero
	localparam int UW = COEF_FRAC_BITS + 18;
	localparam logic [UW-1:0] SAT = {1'b1, {(UW-1){1'b0}}};

	logic                     vld_s1;
	logic signed [OD_W-1:0]   od_r_s1, od_g_s1, od_b_s1;
	logic                     vld_s2;
	logic signed [PROD_W-1:0] prod_r_s2, prod_g_s2, prod_b_s2;
	logic signed [SUM_W-1:0]  sum_w;
	logic [UW-1:0]            sum_clamp;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// stage 1: optical density lookup
	always_ff @(posedge clk) begin
		od_r_s1 <= signed'(OD_TABLE[red]);
		od_g_s1 <= signed'(OD_TABLE[green]);
		od_b_s1 <= signed'(OD_TABLE[blue]);
	end

	// stage 2: weight each density
	always_ff @(posedge clk) begin
		prod_r_s2 <= coef_red   * od_r_s1;
		prod_g_s2 <= coef_green * od_g_s1;
		prod_b_s2 <= coef_blue  * od_b_s1;
	end

	// stage 3: sum, clamp negatives to zero and large sums to SAT
	assign sum_w = SUM_W'(prod_r_s2) + SUM_W'(prod_g_s2) + SUM_W'(prod_b_s2);

	always_comb begin
		priority if (sum_w[SUM_W-1])
			sum_clamp = '0;
		else if (sum_w[SUM_W-2:UW-1] != '0)
			sum_clamp = SAT;
		else
			sum_clamp = sum_w[UW-1:0];
	end

	always_ff @(posedge clk) begin
		sum_s3 <= sum_clamp;
	end

endmodule

### rtl/scd_search_stage.sv
// ----------------------------------------------------------------------------
// scd_search_stage
// One bit of the output level search: try the bit, keep it if the sum is
// within that level's bound.
// ----------------------------------------------------------------------------
module scd_search_stage import scd_pkg::*; #(
	parameter int COEF_FRAC_BITS = 12,
	parameter int BIT            = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          vld_in,
	input  logic [LEVEL_W-1:0]            level_in,
	input  logic [COEF_FRAC_BITS+17:0]    sum_in,
	output logic                          vld_sn,
	output logic [LEVEL_W-1:0]            level_sn,
	output logic [COEF_FRAC_BITS+17:0]    sum_sn
);

	localparam int UW = COEF_FRAC_BITS + 18;
	localparam thr_tab_t THR = build_thr_table(COEF_FRAC_BITS);
	localparam logic [LEVEL_W-1:0] BIT_MASK = LEVEL_W'(1 << BIT);

	logic [LEVEL_W-1:0] cand;
	logic [UW-1:0]      bound;

	assign cand  = level_in | BIT_MASK;
	assign bound = THR[cand][UW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn <= 1'b0;
		end else begin
			vld_sn <= vld_in;
		end
	end

	// keep the candidate bit when the level still holds
	always_ff @(posedge clk) begin
		level_sn <= (sum_in <= bound) ? cand : level_in;
		sum_sn   <= sum_in;
	end

endmodule

### rtl/stain_color_deconvolution_core.sv
// ----------------------------------------------------------------------------
// stain_color_deconvolution_core
// Per-pixel stain intensity from RGB by color deconvolution.
// ----------------------------------------------------------------------------
// Usage:
//   A pixel (red, green, blue) is taken at each rising edge with start high
//   and busy low. busy is always low: one pixel can enter every cycle.
//   stain_level is shown with done for one cycle, once the pixel has passed
//   11 register stages, the first loaded at the edge that took the pixel;
//   results leave in input order, one per cycle at most.
//   The stages are 3 front stages (density lookup, multiply, sum/clamp)
//   and 8 stages of the bitwise level search, one output bit per stage.
//   The receiver cannot stall; it must take each result when done is high.
//   Coefficients are written through cfg_we / cfg_idx / cfg_wdata (signed,
//   COEF_FRAC_BITS fraction bits) while no pixel is in flight; index 3 is
//   ignored. Reset (arst_n low) empties the pipeline and loads the
//   hematoxylin coefficients. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module stain_color_deconvolution_core import scd_pkg::*; #(
	parameter int COEF_FRAC_BITS = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [PIX_W-1:0]   red,
	input  logic [PIX_W-1:0]   green,
	input  logic [PIX_W-1:0]   blue,
	output logic               done,
	output logic [LEVEL_W-1:0] stain_level,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [COEF_W-1:0]  cfg_wdata
);

	localparam int UW = COEF_FRAC_BITS + 18;
	localparam logic [UW-1:0] SAT = {1'b1, {(UW-1){1'b0}}};

	logic signed [COEF_W-1:0] coef_red_q, coef_green_q, coef_blue_q;
	logic                     vld_s3;
	logic [UW-1:0]            sum_s3;
	logic                     vld_c   [0:LEVEL_W];
	logic [LEVEL_W-1:0]       level_c [0:LEVEL_W];
	logic [UW-1:0]            sum_c   [0:LEVEL_W];

	// fully pipelined: never refuses a transaction
	assign busy = 1'b0;

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_red_q   <= COEF_RED_RST;
			coef_green_q <= COEF_GREEN_RST;
			coef_blue_q  <= COEF_BLUE_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_COEF_RED:   coef_red_q   <= signed'(cfg_wdata);
				REG_COEF_GREEN: coef_green_q <= signed'(cfg_wdata);
				REG_COEF_BLUE:  coef_blue_q  <= signed'(cfg_wdata);
				default: ;
			endcase
		end
	end

	// density, weighting and sum
	scd_od_weight #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_od_weight (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_vld     (start && !busy),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.coef_red   (coef_red_q),
		.coef_green (coef_green_q),
		.coef_blue  (coef_blue_q),
		.vld_s3     (vld_s3),
		.sum_s3     (sum_s3)
	);

	// level search, MSB first
	assign vld_c[0]   = vld_s3;
	assign level_c[0] = '0;
	assign sum_c[0]   = sum_s3;

	for (genvar g = 0; g < LEVEL_W; g++) begin : g_search
		scd_search_stage #(
			.COEF_FRAC_BITS (COEF_FRAC_BITS),
			.BIT            (LEVEL_W - 1 - g)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.vld_in   (vld_c[g]),
			.level_in (level_c[g]),
			.sum_in   (sum_c[g]),
			.vld_sn   (vld_c[g+1]),
			.level_sn (level_c[g+1]),
			.sum_sn   (sum_c[g+1])
		);
	end

	assign done        = vld_c[LEVEL_W];
	assign stain_level = level_c[LEVEL_W];

`ifndef NO_ASSERTIONS
	// every valid sum comes out of the search stages with done raised
	a_search_latency: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> ##8 done)
		else $error("result strobe out of step with the sum stage");

	// zero or negative sum gives no stain
	a_zero_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(done && sum_c[LEVEL_W] == '0) |-> (stain_level == '1))
		else $error("zero sum did not give full level");

	// saturated sum gives level zero
	a_sat_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(done && sum_c[LEVEL_W] == SAT) |-> (stain_level == '0))
		else $error("saturated sum did not give level zero");
`endif

endmodule

### tb/stain_color_deconvolution_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stain_color_deconvolution_core_tb
// Self-checking bench for the stain color deconvolution core. An in-bench
// model of the density lookup, weighted sum and level search predicts each
// pixel whose level the directed table does not give; results are compared
// in order against a queue of expected levels. A short directed table (reset
// values, saturating weights, zero sum, the level 0/1 boundary) is followed
// by random pixels under many weight settings, sent in random bursts.
// ----------------------------------------------------------------------------
module stain_color_deconvolution_core_tb;
	import scd_pkg::*;

	localparam int COEF_FRAC  = 12;
	localparam int SUM_SHIFT  = COEF_FRAC + 8;
	localparam int N_PHASES   = 10;
	localparam int PHASE_PIX  = 193;
	localparam int DRAIN_MAX  = 200;
	localparam int TAIL_CYC   = 16;
	localparam int MAX_REPORT = 10;
	localparam int N_DIR      = 23;

	// Index that decodes to no register
	localparam logic [1:0] REG_UNUSED = 2'd3;
	// Marker in the directed table: level comes from the in-bench model
	localparam logic [8:0] CALC = 9'h100;

	typedef struct packed {
		logic [1:0] set_id;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [8:0] lvl;
	} pixel_vec_t;

	// DUT ports
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [PIX_W-1:0]   red = '0;
	logic [PIX_W-1:0]   green = '0;
	logic [PIX_W-1:0]   blue = '0;
	logic               done;
	logic [LEVEL_W-1:0] stain_level;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_idx = REG_COEF_RED;
	logic [COEF_W-1:0]  cfg_wdata = '0;

	// Bench state
	logic signed [COEF_W-1:0] wt_red   = COEF_RED_RST;
	logic signed [COEF_W-1:0] wt_green = COEF_GREEN_RST;
	logic signed [COEF_W-1:0] wt_blue  = COEF_BLUE_RST;
	longint     od_q8 [256];
	longint     level_floor [256];
	longint     log2_255_q24;
	logic [7:0] level_q [$];
	logic [8:0] typed_lvl = CALC;
	int         n_errors = 0;
	int         n_pixels = 0;
	int         n_results = 0;
	int         n_settings = 1;
	int         n_black = 0;
	int         n_white = 0;
	int         n_mid = 0;
	int         burst_left = 0;

	pixel_vec_t dir_tab [N_DIR] = '{
		// reset weights (hematoxylin row)
		'{0, 255, 255, 255, 255},
		'{0,   0,   0, 255,   0},
		'{0,   0, 255,   0, CALC},
		'{0,   0,   0,   0, CALC},
		'{0,   0, 255, 255, CALC},
		'{0, 128,  64, 200, CALC},
		'{0, 200, 100,  50, CALC},
		'{0, 254, 254, 254, 255},
		// all weights at positive full scale
		'{1,   0,   0,   0,   0},
		'{1, 255, 255, 255, 255},
		'{1, 254, 254, 254, 255},
		'{1,   0, 255, 255,   0},
		'{1, 100, 100, 100, CALC},
		// all weights at negative full scale
		'{2,   0,   0,   0, 255},
		'{2, 128, 128, 128, 255},
		'{2, 255, 255, 255, CALC},
		'{2, 255, 254, 255, CALC},
		// red only at 2.0: sweeps across the half point between levels 0 and 1
		'{3,   9,  17, 200, CALC},
		'{3,  10, 255,   0, CALC},
		'{3,  11,   0,   0, CALC},
		'{3,  12,  99,   3, CALC},
		'{3, 254,   0,   0, 255},
		'{3, 255,   0,   0, 255}
	};

	logic signed [COEF_W-1:0] dir_coefs [4][3] = '{
		'{COEF_RED_RST, COEF_GREEN_RST, COEF_BLUE_RST},
		'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF},
		'{16'sh8000, 16'sh8000, 16'sh8000},
		'{16'sh2000, 16'sh0000, 16'sh0000}
	};

	stain_color_deconvolution_core #(
		.COEF_FRAC_BITS(COEF_FRAC)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.done       (done),
		.stain_level(stain_level),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Base-2 log, LOG_FRAC fraction bits, by repeated squaring (truncating)
	function automatic longint log2_q24(input int unsigned x);
		int unsigned ip;
		logic [63:0] y;
		logic [63:0] frac;
		ip   = 0;
		frac = '0;
		while (ip < 9 && (x >> (ip + 1)) != 0)
			ip++;
		y = 64'(x) << (LOG_FRAC - ip);
		for (int i = 0; i < LOG_FRAC; i++) begin
			y    = (y * y) >> LOG_FRAC;
			frac = frac << 1;
			if (y >= (64'd2 << LOG_FRAC)) begin
				y       = y >> 1;
				frac[0] = 1'b1;
			end
		end
		return longint'((64'(ip) << LOG_FRAC) | frac);
	endfunction

	// Expected stain level for one pixel under the current weights
	function automatic logic [7:0] predict_stain(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		longint s;
		longint den;
		longint num;
		int     lo;
		int     hi;
		int     mid;
		s = longint'(wt_red) * od_q8[r] + longint'(wt_green) * od_q8[g]
			+ longint'(wt_blue) * od_q8[b];
		if (s <= 0)
			return 8'd255;
		if (s >= (longint'(512) <<< SUM_SHIFT))
			return 8'd0;
		den = longint'(255) <<< SUM_SHIFT;
		num = log2_255_q24 * (den - s);
		// largest level whose threshold the scaled log still reaches
		lo = 0;
		hi = 255;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (num >= level_floor[mid] * den)
				lo = mid;
			else
				hi = mid - 1;
		end
		return 8'(lo);
	endfunction

	task automatic report_error(input string msg);
		if (n_errors < MAX_REPORT)
			$display("ERROR @%0t: %s", $realtime, msg);
		n_errors++;
	endtask

	// Result check and expectation capture
	always @(posedge clk) begin : monitor
		logic [7:0] want;
		if (arst_n) begin
			if (done) begin
				if (level_q.size() == 0) begin
					report_error($sformatf("result %0d with no pixel outstanding", stain_level));
				end else begin
					want = level_q.pop_front();
					if (stain_level !== want)
						report_error($sformatf("stain_level exp %0d got %0d (result %0d)",
							want, stain_level, n_results));
					n_results++;
				end
				if (stain_level == 8'd0)
					n_black++;
				else if (stain_level == 8'd255)
					n_white++;
				else
					n_mid++;
			end
			if (start && !busy) begin
				level_q.push_back(typed_lvl[8] ? predict_stain(red, green, blue) : typed_lvl[7:0]);
				n_pixels++;
			end
		end
	end

	task automatic go_idle();
		start <= 1'b0;
	endtask

	// Wait until every pixel in flight has produced its result
	task automatic wait_drained();
		// one edge first, so the last accepted pixel is already queued
		@(posedge clk);
		for (int i = 0; i < DRAIN_MAX && level_q.size() != 0; i++)
			@(posedge clk);
		if (level_q.size() != 0) begin
			report_error($sformatf("%0d results never arrived", level_q.size()));
			level_q.delete();
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [COEF_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_COEF_RED:   wt_red   = val;
			REG_COEF_GREEN: wt_green = val;
			REG_COEF_BLUE:  wt_blue  = val;
			default: ;
		endcase
	endtask

	// Load one weight row; also pokes the unused index, which must not land
	task automatic load_weights(input logic [COEF_W-1:0] wr, input logic [COEF_W-1:0] wg,
			input logic [COEF_W-1:0] wb);
		go_idle();
		wait_drained();
		write_reg(REG_COEF_RED, wr);
		write_reg(REG_COEF_GREEN, wg);
		write_reg(REG_COEF_BLUE, wb);
		write_reg(REG_UNUSED, 16'($urandom));
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	// One pixel transaction; start stays high if the caller sends again at once
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		start <= 1'b1;
		red   <= r;
		green <= g;
		blue  <= b;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Sender in bursts with random gaps (back-to-back bursts when gap is zero)
	task automatic send_bursty(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 30) : $urandom_range(0, 4);
			if (gap > 0) begin
				go_idle();
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 48);
		end
		burst_left--;
		send_pixel(r, g, b);
	endtask

	function automatic logic [7:0] jitter(input int base, input int spread);
		int v;
		v = base + $urandom_range(0, 2 * spread) - spread;
		return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
	endfunction

	function automatic logic [7:0] edge_byte();
		case ($urandom_range(0, 3))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd254;
			default: return 8'd255;
		endcase
	endfunction

	function automatic logic [COEF_W-1:0] extreme_coef();
		case ($urandom_range(0, 4))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'h0001;
			default: return 16'hFFFF;
		endcase
	endfunction

	function automatic logic [COEF_W-1:0] modest_coef();
		return 16'($urandom_range(0, 16383) - 8192);
	endfunction

	// Main sequence
	initial begin : stimulus
		logic [7:0]        pr;
		logic [7:0]        pg;
		logic [7:0]        pb;
		logic [COEF_W-1:0] cr;
		logic [COEF_W-1:0] cg;
		logic [COEF_W-1:0] cb;
		int                cur_set;
		int                base;

		log2_255_q24 = log2_q24(255);
		for (int c = 0; c < 256; c++) begin
			longint num;
			num = longint'(65280) * (log2_255_q24 - log2_q24(c + 1));
			if (num >= 0)
				od_q8[c] = (num + log2_255_q24 / 2) / log2_255_q24;
			else
				od_q8[c] = -((-num + log2_255_q24 / 2) / log2_255_q24);
		end
		level_floor[0] = 0;
		for (int k = 1; k < 256; k++)
			level_floor[k] = log2_q24(2 * k - 1) - (longint'(1) <<< LOG_FRAC);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		cur_set = 0;
		for (int i = 0; i < N_DIR; i++) begin
			if (int'(dir_tab[i].set_id) != cur_set) begin
				cur_set = dir_tab[i].set_id;
				load_weights(dir_coefs[cur_set][0], dir_coefs[cur_set][1], dir_coefs[cur_set][2]);
			end
			typed_lvl <= dir_tab[i].lvl;
			send_pixel(dir_tab[i].r, dir_tab[i].g, dir_tab[i].b);
		end
		typed_lvl <= CALC;

		// Random pixels, one weight setting per phase
		for (int p = 0; p < N_PHASES; p++) begin
			case (p)
				0: begin cr = COEF_RED_RST; cg = COEF_GREEN_RST; cb = COEF_BLUE_RST; end
				1: begin cr = 16'h7FFF; cg = 16'h7FFF; cb = 16'h7FFF; end
				2: begin cr = 16'h8000; cg = 16'h8000; cb = 16'h8000; end
				3: begin cr = 16'h0000; cg = 16'h0000; cb = 16'h0000; end
				4: begin cr = extreme_coef(); cg = extreme_coef(); cb = extreme_coef(); end
				9: begin cr = 16'($urandom); cg = 16'($urandom); cb = 16'($urandom); end
				default: begin cr = modest_coef(); cg = modest_coef(); cb = modest_coef(); end
			endcase
			load_weights(cr, cg, cb);
			burst_left = 0;
			for (int n = 0; n < PHASE_PIX; n++) begin
				// in odd phases, a mid-phase full stop until the pipeline is empty
				if (p[0] && n == PHASE_PIX / 2) begin
					go_idle();
					wait_drained();
				end
				case ($urandom_range(0, 9))
					0, 1, 2, 3: begin
						pr = 8'($urandom); pg = 8'($urandom); pb = 8'($urandom);
					end
					4, 5, 6: begin
						base = $urandom_range(0, 255);
						pr = jitter(base, 40); pg = jitter(base, 40); pb = jitter(base, 40);
					end
					7: begin
						pr = 8'($urandom); pg = pr; pb = pr;
					end
					8: begin
						pr = edge_byte(); pg = edge_byte(); pb = edge_byte();
					end
					default: begin
						pr = 8'd255; pg = 8'd255; pb = 8'd255;
						case ($urandom_range(0, 2))
							0: pr = 8'($urandom);
							1: pg = 8'($urandom);
							default: pb = 8'($urandom);
						endcase
					end
				endcase
				send_bursty(pr, pg, pb);
			end
		end

		go_idle();
		wait_drained();
		repeat (TAIL_CYC) @(posedge clk);

		$display("Checked %0d of %0d pixels over %0d weight settings", n_results, n_pixels,
			n_settings);
		$display("Levels seen: %0d at 0, %0d at 255, %0d in between; %0d errors",
			n_black, n_white, n_mid, n_errors);
		if (n_errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

### sim.f
rtl/scd_pkg.sv
rtl/scd_od_weight.sv
rtl/scd_search_stage.sv
rtl/stain_color_deconvolution_core.sv
tb/stain_color_deconvolution_core_tb.sv
